// ===== design/pcg32_random_word_generator_unit_defines.svh =====
// assertion macros for the pcg32 random word generator unit
// no dependencies; included by the top level only
`ifndef PCG32_RANDOM_WORD_GENERATOR_UNIT_DEFINES_SVH
`define PCG32_RANDOM_WORD_GENERATOR_UNIT_DEFINES_SVH

// consequent checked at the same edge as the antecedent
`define PCGRW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked at the edge after the antecedent
`define PCGRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pcgrw_pkg.sv =====
// shared types and constants of the pcg32 random word generator unit
// no dependencies
package pcgrw_pkg;

    localparam int SEED_W       = 64;
    localparam int STATE_W      = 64;
    localparam int WORD_W       = 32;
    localparam int BYTE_COUNT_W = 9;
    localparam int VBYTES_W     = 3;

    localparam int DEF_MAX_REQUEST_BYTES = 256;

    localparam logic [WORD_W-1:0]  GEN_MULT  = 32'hf13283ad;
    localparam logic [STATE_W-1:0] GEN_RESET = 64'd130973517;
    localparam int XS_SHIFT  = 22;
    localparam int TOP_SHIFT = 61;
    localparam int TOP_W     = STATE_W - TOP_SHIFT;

    localparam logic [VBYTES_W-1:0] FULL_WORD_BYTES = 3'd4;

    localparam int CMDQ_DEPTH = 2;

    typedef logic t_cmd_kind;
    localparam t_cmd_kind CMD_SEED  = 1'b0;
    localparam t_cmd_kind CMD_BYTES = 1'b1;

    // seed commands carry the seed, byte commands the saturated count in the low bits
    typedef struct packed {
        t_cmd_kind          kind;
        logic [SEED_W-1:0]  arg;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic draw_fire;
        logic kind_bytes;
    } t_back_status;

endpackage

// ===== design/pcgrw_if.sv =====
// request and result channel interfaces of the pcg32 random word generator unit
// depends on pcgrw_pkg
interface pcgrw_req_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [pcgrw_pkg::SEED_W-1:0]        seed_value;
    logic [pcgrw_pkg::BYTE_COUNT_W-1:0]  byte_count;

    modport source (output valid, output func, output seed_value, output byte_count,
                    input ready);
    modport sink   (input valid, input func, input seed_value, input byte_count,
                    output ready);
endinterface

interface pcgrw_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pcgrw_pkg::WORD_W-1:0]      random_word;
    logic [pcgrw_pkg::VBYTES_W-1:0]    valid_bytes;
    logic                              last_word;

    modport source (output valid, output random_word, output valid_bytes, output last_word,
                    input ready);
    modport sink   (input valid, input random_word, input valid_bytes, input last_word,
                    output ready);
endinterface

// ===== design/pcgrw_front.sv =====
// front end: accepts items, saturates byte counts, drops empty requests
// depends on pcgrw_pkg and pcgrw_if
module pcgrw_front #(
    parameter int MAX_REQUEST_BYTES = pcgrw_pkg::DEF_MAX_REQUEST_BYTES
) (
    pcgrw_req_if.sink          i_req,
    input  logic               i_q_ready,
    output logic               o_push,
    output pcgrw_pkg::t_cmd    o_cmd
);
    import pcgrw_pkg::*;

    localparam logic [31:0] MAX_U = 32'(MAX_REQUEST_BYTES);

    logic [BYTE_COUNT_W-1:0] w_count;
    logic                    w_empty;

    always_comb begin
        if ({{(32-BYTE_COUNT_W){1'b0}}, i_req.byte_count} > MAX_U) begin
            w_count = MAX_U[BYTE_COUNT_W-1:0];
        end else begin
            w_count = i_req.byte_count;
        end
    end

    assign w_empty = (i_req.func == CMD_BYTES) && (i_req.byte_count == '0);

    assign i_req.ready = i_q_ready;
    // zero-length requests complete here without a queue entry
    assign o_push      = i_req.valid && i_q_ready && !w_empty;
    assign o_cmd.kind  = i_req.func;
    assign o_cmd.arg   = (i_req.func == CMD_SEED) ? i_req.seed_value : SEED_W'(w_count);

endmodule

// ===== design/pcgrw_cmd_queue.sv =====
// short command queue between the front end and the generator
// depends on pcgrw_pkg
module pcgrw_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pcgrw_pkg::t_cmd    i_cmd,
    output logic               o_ready,
    output logic               o_valid,
    output pcgrw_pkg::t_cmd    o_cmd,
    input  logic               i_pop
);
    import pcgrw_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_count != CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== design/pcgrw_back.sv =====
// back end: generator state, shared 32x32 multiplier, word output register
// depends on pcgrw_pkg and pcgrw_if
module pcgrw_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  pcgrw_pkg::t_cmd          i_cmd,
    output logic                     o_cmd_pop,
    pcgrw_rsp_if.source              o_rsp,
    output pcgrw_pkg::t_back_status  o_status
);
    import pcgrw_pkg::*;

    localparam int HALF_W = STATE_W / 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DRAW = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;

    logic [1:0]              r_st,        n_st;
    t_cmd_kind               r_kind,      n_kind;
    logic [BYTE_COUNT_W-1:0] r_left,      n_left;
    logic [STATE_W-1:0]      r_state,     n_state;
    logic [STATE_W-1:0]      r_plo,       n_plo;
    logic                    r_out_valid, n_out_valid;
    logic [WORD_W-1:0]       r_word,      n_word;
    logic [VBYTES_W-1:0]     r_vbytes,    n_vbytes;
    logic                    r_last,      n_last;

    logic                    w_out_free;
    logic                    w_fire;
    logic [HALF_W-1:0]       w_mul_a;
    logic [STATE_W-1:0]      w_prod;
    logic [STATE_W-1:0]      w_xs;
    logic [STATE_W-1:0]      w_sh;
    logic [TOP_W-1:0]        w_top;
    logic [VBYTES_W-1:0]     w_take;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_fire     = (r_st == ST_DRAW) && ((r_kind == CMD_SEED) || w_out_free);

    // low half of the state in the draw pass, high half in the advance pass
    assign w_mul_a = (r_st == ST_ADV) ? r_state[STATE_W-1:HALF_W] : r_state[HALF_W-1:0];
    assign w_prod  = STATE_W'(w_mul_a) * STATE_W'(GEN_MULT);

    // output permutation on the old state
    assign w_top = r_state[STATE_W-1:TOP_SHIFT];
    assign w_xs  = r_state ^ (r_state >> XS_SHIFT);
    assign w_sh  = (w_xs >> XS_SHIFT) >> w_top;

    assign w_take = (r_left < BYTE_COUNT_W'(FULL_WORD_BYTES)) ?
                    r_left[VBYTES_W-1:0] : FULL_WORD_BYTES;

    always_comb begin
        n_st        = r_st;
        n_kind      = r_kind;
        n_left      = r_left;
        n_state     = r_state;
        n_plo       = r_plo;
        n_out_valid = r_out_valid;
        n_word      = r_word;
        n_vbytes    = r_vbytes;
        n_last      = r_last;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_kind = i_cmd.kind;
                    n_st   = ST_DRAW;
                    if (i_cmd.kind == CMD_SEED) begin
                        n_state = {i_cmd.arg[SEED_W-2:0], 1'b1};
                    end else begin
                        n_left = i_cmd.arg[BYTE_COUNT_W-1:0];
                    end
                end
            end
            ST_DRAW: begin
                if (w_fire) begin
                    n_plo = w_prod;
                    n_st  = ST_ADV;
                    // the draw after a seed load is discarded
                    if (r_kind == CMD_BYTES) begin
                        n_out_valid = 1'b1;
                        n_word      = w_sh[WORD_W-1:0];
                        n_vbytes    = w_take;
                        n_last      = (r_left <= BYTE_COUNT_W'(FULL_WORD_BYTES));
                        n_left      = r_left - BYTE_COUNT_W'(w_take);
                    end
                end
            end
            ST_ADV: begin
                n_state = {w_prod[HALF_W-1:0] + r_plo[STATE_W-1:HALF_W], r_plo[HALF_W-1:0]};
                n_st    = ((r_kind == CMD_SEED) || (r_left == '0)) ? ST_IDLE : ST_DRAW;
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_state     <= GEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_left   <= n_left;
        r_plo    <= n_plo;
        r_word   <= n_word;
        r_vbytes <= n_vbytes;
        r_last   <= n_last;
    end

    assign o_cmd_pop         = (r_st == ST_IDLE) && i_cmd_valid;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.random_word = r_word;
    assign o_rsp.valid_bytes = r_vbytes;
    assign o_rsp.last_word   = r_last;

    assign o_status.idle       = (r_st == ST_IDLE);
    assign o_status.draw_fire  = w_fire;
    assign o_status.kind_bytes = (r_kind == CMD_BYTES);

endmodule

// ===== design/pcg32_random_word_generator_unit.sv =====
// channel     | dir | payload                                | transfer when
// i_req       | in  | func, seed_value, byte_count           | valid && ready
// o_rsp       | out | random_word, valid_bytes, last_word    | valid && ready
//
// each state step uses the one shared 32x32 multiplier twice (low half, then high half),
// so a request holds the generator for one draw and one advance per word, and a seed for one of each.
// i_req is ready while the two-entry command queue has room, also while a word waits on o_rsp.
// a stalled o_rsp holds the generator before its next draw; seeds never wait on o_rsp.
// reset (synchronous, active low) loads the state 130973517 and empties queue and output.
// depends on pcgrw_pkg, pcgrw_if, pcgrw_front, pcgrw_cmd_queue, pcgrw_back and the defines header
`include "pcg32_random_word_generator_unit_defines.svh"

module pcg32_random_word_generator_unit #(
    parameter int MAX_REQUEST_BYTES = pcgrw_pkg::DEF_MAX_REQUEST_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcgrw_req_if.sink     i_req,
    pcgrw_rsp_if.source   o_rsp
);
    import pcgrw_pkg::*;

    logic          w_push;
    t_cmd          w_front_cmd;
    logic          w_q_ready;
    logic          w_q_valid;
    t_cmd          w_q_cmd;
    logic          w_pop;
    t_back_status  w_status;

    pcgrw_front #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_front (
        .i_req     (i_req),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_front_cmd)
    );

    pcgrw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pcgrw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_rsp       (o_rsp),
        .o_status    (w_status)
    );

    `PCGRW_ASSERT_SAME(a_zero_len_dropped, i_clk, i_rst_n, i_req.valid && i_req.ready && (i_req.func == CMD_BYTES) && (i_req.byte_count == '0), !w_push, "zero-length request entered the queue")
    `PCGRW_ASSERT_SAME(a_word_from_draw, i_clk, i_rst_n, $rose(o_rsp.valid), $past(w_status.draw_fire && w_status.kind_bytes), "result appeared without a request draw")
    `PCGRW_ASSERT_NEXT(a_idle_takes_cmd, i_clk, i_rst_n, w_status.idle && w_q_valid, !w_status.idle, "generator ignored a queued command")
    `PCGRW_ASSERT_SAME(a_partial_is_last, i_clk, i_rst_n, o_rsp.valid && !o_rsp.last_word, o_rsp.valid_bytes == FULL_WORD_BYTES, "partial word before the end of a request")

endmodule

// ===== sim/pcg32_random_word_generator_unit_tb.sv =====
// self-checking testbench of the pcg32 random word generator unit: directed and random
// seed and byte requests, each result checked against a behavioral generator mirror
// depends on pcgrw_pkg, pcgrw_if and pcg32_random_word_generator_unit
`timescale 1ns / 100ps

module pcg32_random_word_generator_unit_tb;
    import pcgrw_pkg::*;

    localparam int MAX_BYTES       = DEF_MAX_REQUEST_BYTES;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLDOFF_AFTER   = 60;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int TAIL_CYCLES     = 100;
    localparam int IDLE_PERCENT    = 16;

    typedef struct {
        t_cmd_kind                 func;
        logic [SEED_W-1:0]         seed_value;
        logic [BYTE_COUNT_W-1:0]   byte_count;
    } t_gen_cmd;

    typedef struct {
        logic [WORD_W-1:0]    random_word;
        logic [VBYTES_W-1:0]  valid_bytes;
        logic                 last_word;
    } t_word_result;

    logic i_clk;
    logic i_rst_n;

    pcgrw_req_if req_ch ();
    pcgrw_rsp_if rsp_ch ();

    pcg32_random_word_generator_unit #(
        .MAX_REQUEST_BYTES (MAX_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_gen_cmd           cmd_backlog[$];
    t_word_result       expected_words[$];
    logic [STATE_W-1:0] gen_state_mirror = GEN_RESET;
    logic               req_fire = 1'b0;
    int                 req_count = 0;
    int                 mismatch_count = 0;
    int                 stuck_cycles = 0;
    int                 holdoff_left = 0;
    bit                 holdoff_done = 1'b0;
    bit                 no_idle = 1'b0;

    // one draw: word from the old state, state advanced by the multiplier
    function automatic logic [WORD_W-1:0] next_random_word();
        logic [STATE_W-1:0] old_state;
        logic [STATE_W-1:0] mixed;
        logic [TOP_W-1:0]   top;
        old_state = gen_state_mirror;
        top = old_state[STATE_W-1 -: TOP_W];
        gen_state_mirror = old_state * STATE_W'(GEN_MULT);
        mixed = old_state ^ (old_state >> XS_SHIFT);
        mixed = mixed >> (XS_SHIFT + int'(top));
        return mixed[WORD_W-1:0];
    endfunction

    function automatic void predict_cmd(t_gen_cmd c);
        int           remaining;
        t_word_result w;
        if (c.func == CMD_SEED) begin
            gen_state_mirror = {c.seed_value[SEED_W-2:0], 1'b1};
            void'(next_random_word());
        end else begin
            remaining = (int'(c.byte_count) > MAX_BYTES) ? MAX_BYTES : int'(c.byte_count);
            while (remaining > 0) begin
                w.random_word = next_random_word();
                w.valid_bytes = (remaining < 4) ? remaining[VBYTES_W-1:0] : FULL_WORD_BYTES;
                remaining -= (remaining < 4) ? remaining : 4;
                w.last_word = (remaining == 0);
                expected_words.push_back(w);
            end
        end
    endfunction

    function automatic void queue_cmd(t_cmd_kind f, logic [SEED_W-1:0] s,
                                      logic [BYTE_COUNT_W-1:0] n);
        t_gen_cmd c;
        c.func = f;
        c.seed_value = s;
        c.byte_count = n;
        cmd_backlog.push_back(c);
    endfunction

    function automatic t_gen_cmd random_cmd();
        t_gen_cmd    c;
        int unsigned roll;
        roll = $urandom_range(99);
        c.seed_value = {$urandom, $urandom};
        c.byte_count = BYTE_COUNT_W'($urandom_range(511));
        if (roll < 15) begin
            c.func = CMD_SEED;
        end else begin
            c.func = CMD_BYTES;
            if (roll < 20) begin
                c.byte_count = '0;
            end else if (roll < 90) begin
                c.byte_count = BYTE_COUNT_W'($urandom_range(40, 1));
            end else if (roll < 97) begin
                c.byte_count = BYTE_COUNT_W'($urandom_range(MAX_BYTES, 41));
            end
            // the rest keeps the full 9-bit range, oversized counts included
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || req_ch.valid || expected_words.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        t_gen_cmd c;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
                c = cmd_backlog.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.func       <= c.func;
                req_ch.seed_value <= c.seed_value;
                req_ch.byte_count <= c.byte_count;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off once the stream is going
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (!holdoff_done && req_count >= HOLDOFF_AFTER) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // monitor: results are checked before the same-edge request is predicted
    always @(posedge i_clk) begin
        t_word_result exp_w;
        if (!i_rst_n) begin
            gen_state_mirror = GEN_RESET;
            expected_words.delete();
            req_fire  <= 1'b0;
            req_count <= 0;
        end else begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %08h", rsp_ch.random_word));
                end else begin
                    exp_w = expected_words.pop_front();
                    if (rsp_ch.random_word !== exp_w.random_word)
                        report_mismatch($sformatf("random_word %08h, want %08h",
                                                  rsp_ch.random_word, exp_w.random_word));
                    if (rsp_ch.valid_bytes !== exp_w.valid_bytes)
                        report_mismatch($sformatf("valid_bytes %0d, want %0d",
                                                  rsp_ch.valid_bytes, exp_w.valid_bytes));
                    if (rsp_ch.last_word !== exp_w.last_word)
                        report_mismatch($sformatf("last_word %0b, want %0b",
                                                  rsp_ch.last_word, exp_w.last_word));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                predict_cmd('{req_ch.func, req_ch.seed_value, req_ch.byte_count});
                req_count <= req_count + 1;
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = CMD_BYTES;
        req_ch.seed_value = '0;
        req_ch.byte_count = '0;
        rsp_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, partial and full words, zero and oversized counts,
        // ignored fields on both kinds, seed extremes
        queue_cmd(CMD_BYTES, '0, 9'd4);
        queue_cmd(CMD_BYTES, '0, 9'd0);
        queue_cmd(CMD_BYTES, '0, 9'd1);
        queue_cmd(CMD_BYTES, '0, 9'd2);
        queue_cmd(CMD_BYTES, '0, 9'd3);
        queue_cmd(CMD_BYTES, '0, 9'd5);
        queue_cmd(CMD_BYTES, '0, 9'd256);
        queue_cmd(CMD_BYTES, '0, 9'd257);
        queue_cmd(CMD_BYTES, '0, 9'd511);
        queue_cmd(CMD_SEED, '0, 9'd511);
        queue_cmd(CMD_BYTES, '1, 9'd7);
        queue_cmd(CMD_SEED, '1, 9'd0);
        queue_cmd(CMD_BYTES, '0, 9'd8);
        queue_cmd(CMD_SEED, 64'h8000_0000_0000_0000, 9'd256);
        queue_cmd(CMD_BYTES, '0, 9'd12);
        queue_cmd(CMD_SEED, {$urandom, $urandom}, 9'd3);
        queue_cmd(CMD_BYTES, '0, 9'd0);
        queue_cmd(CMD_BYTES, {$urandom, $urandom}, 9'd255);
        queue_cmd(CMD_SEED, 64'h7fff_ffff_ffff_ffff, 9'd1);
        queue_cmd(CMD_BYTES, '0, 9'd9);
        queue_cmd(CMD_SEED, 64'h5555_5555_aaaa_aaaa, 9'd170);
        queue_cmd(CMD_BYTES, 64'haaaa_aaaa_5555_5555, 9'd85);
        wait_drained();

        repeat (170) cmd_backlog.push_back(random_cmd());
        wait_drained();

        // back-to-back stretch on both sides
        no_idle = 1'b1;
        repeat (80) cmd_backlog.push_back(random_cmd());
        wait_drained();
        no_idle = 1'b0;

        repeat (90) cmd_backlog.push_back(random_cmd());
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
